// ===== hw/rtl/token_bucket_rate_limiter_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the token bucket rate limiter
// Concurrent property wrappers with an explicit clock, disable and message.
// ----------------------------------------------------------------------------
`ifndef TOKEN_BUCKET_RATE_LIMITER_MACROS_SVH
`define TOKEN_BUCKET_RATE_LIMITER_MACROS_SVH

// same-cycle implication
`define TBRL_ASSERT_IMPL(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TBRL_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tbrl_pkg.sv =====
// ----------------------------------------------------------------------------
// tbrl_pkg
// Shared types and constants of the token bucket rate limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package tbrl_pkg;

  localparam int unsigned MS_TO_US     = 1000;
  localparam int unsigned TMO_US_W     = 26;  // 16-bit ms times 1000
  localparam int unsigned QDEPTH       = 2;   // power of two
  localparam int unsigned QPTR_W       = $clog2(QDEPTH);
  localparam int unsigned QCNT_W       = $clog2(QDEPTH + 1);
  localparam logic [31:0] INTERVAL_RST = 32'd1000;

  // configuration register index, decoded from paddr[2]
  localparam logic REG_INTERVAL   = 1'b0;
  localparam logic REG_MAX_STORED = 1'b1;

  typedef enum logic {
    CMD_ACQUIRE     = 1'b0,
    CMD_TRY_ACQUIRE = 1'b1
  } tbrl_cmd_t;

  typedef enum logic [1:0] {
    ST_GRANTED = 2'd0,
    ST_REFUSED = 2'd1,
    ST_INVALID = 2'd2
  } tbrl_status_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_CHECK,
    BK_AGE,
    BK_DIV,
    BK_CLAIM,
    BK_MUL_HI,
    BK_MUL_LO,
    BK_UPDATE,
    BK_EMIT
  } tbrl_state_t;

  // classified request, as queued between front and back
  typedef struct packed {
    logic        try_acq;
    logic        count_zero;
    logic [63:0] now_us;
    logic [63:0] limit_us;
    logic [15:0] permit_count;
  } tbrl_req_t;

  typedef struct packed {
    logic [31:0] interval_eff;
    logic [15:0] max_stored;
  } tbrl_cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tbrl_front.sv =====
// ----------------------------------------------------------------------------
// tbrl_front
// Input stage: takes a request, works out the try-acquire time limit and
// flags a zero permit count, then hands the request to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tbrl_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire logic                command,
  input  wire logic [63:0]         now_us,
  input  wire logic [15:0]         permit_count,
  input  wire logic [15:0]         timeout_ms,
  output logic                     q_push,
  output tbrl_pkg::tbrl_req_t      q_entry,
  input  wire logic                q_full
);
  import tbrl_pkg::*;

  logic                s_valid;
  logic                s_try;
  logic [63:0]         s_now;
  logic [15:0]         s_count;
  logic [TMO_US_W-1:0] s_tmo_us;
  logic                accept;
  logic [64:0]         limit_sum;

  assign full   = s_valid & q_full;
  assign accept = push & ~full;
  assign q_push = s_valid & ~q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= accept | (s_valid & ~q_push);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_try    <= (command == CMD_TRY_ACQUIRE);
      s_now    <= now_us;
      s_count  <= permit_count;
      s_tmo_us <= TMO_US_W'(timeout_ms) * TMO_US_W'(MS_TO_US);
    end
  end

  // now + timeout, saturating
  assign limit_sum = {1'b0, s_now} + 65'(s_tmo_us);

  always_comb begin
    q_entry.try_acq      = s_try;
    q_entry.count_zero   = (s_count == 16'd0);
    q_entry.now_us       = s_now;
    q_entry.limit_us     = limit_sum[64] ? '1 : limit_sum[63:0];
    q_entry.permit_count = s_count;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tbrl_queue.sv =====
// ----------------------------------------------------------------------------
// tbrl_queue
// Short request queue between front and back stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tbrl_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_en,
  input  tbrl_pkg::tbrl_req_t      wr_data,
  output logic                     full,
  input  wire logic                rd_en,
  output tbrl_pkg::tbrl_req_t      rd_data,
  output logic                     empty
);
  import tbrl_pkg::*;

  tbrl_req_t         entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tbrl_divider.sv =====
// ----------------------------------------------------------------------------
// tbrl_divider
// Bit-serial restoring divider: (dividend << FRAC_BITS) / divisor, one
// quotient bit per cycle, quotient saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tbrl_divider #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);

  localparam int unsigned DW   = 64 + FRAC_BITS;
  localparam int unsigned CNTW = $clog2(DW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [DW-1:0]   shreg;
  logic [31:0]     rem;
  logic [31:0]     q;
  logic            ovf;
  logic [32:0]     trial;
  logic            ge;
  logic [32:0]     diff;

  assign trial    = {rem, shreg[DW-1]};
  assign ge       = (trial >= {1'b0, divisor});
  assign diff     = trial - {1'b0, divisor};
  assign quotient = ovf ? '1 : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= DW'(dividend) << FRAC_BITS;
      rem   <= '0;
      q     <= '0;
      ovf   <= 1'b0;
    end else if (busy) begin
      shreg <= shreg << 1;
      rem   <= ge ? diff[31:0] : trial[31:0];
      q     <= {q[30:0], ge};
      ovf   <= ovf | q[31];  // any bit past 32 means saturation
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tbrl_back.sv =====
// ----------------------------------------------------------------------------
// tbrl_back
// Bucket state and request execution: timeout check, refill through the
// serial divider, claim of banked and fresh permits, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tbrl_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  tbrl_pkg::tbrl_cfg_t       cfg,
  input  wire logic                 q_empty,
  input  tbrl_pkg::tbrl_req_t       q_entry,
  output logic                      q_pop,
  input  wire logic                 pop,
  output logic                      res_valid,
  output tbrl_pkg::tbrl_status_t    res_status,
  output logic [31:0]               res_wait
);
  import tbrl_pkg::*;

  localparam int unsigned WANTW = 16 + FRAC_BITS;
  localparam int unsigned CW    = (WANTW > 32) ? WANTW : 32;
  localparam int unsigned LOW   = FRAC_BITS + 32;

  tbrl_state_t  state;
  tbrl_state_t  state_next;

  logic [63:0]  next_free_time;
  logic [31:0]  banked_permits;

  tbrl_req_t    work;
  tbrl_status_t pend_status;
  logic [31:0]  pend_wait;
  logic [WANTW-1:0] fresh;
  logic [47:0]  prod_hi;
  logic [LOW-1:0] prod_lo;

  logic         div_start;
  logic         div_done;
  logic [31:0]  div_q;
  logic         out_free;

  logic [63:0]  cap64;
  logic [31:0]  cap32;
  logic [32:0]  refill_sum;
  logic [31:0]  refill_bank;
  logic [63:0]  ahead;
  logic [CW-1:0] want;
  logic [CW-1:0] from_bank;
  logic [CW-1:0] fresh_w;
  logic [64:0]  nft_sum;

  assign out_free = ~res_valid | pop;

  tbrl_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (work.now_us - next_free_time),
    .divisor  (cfg.interval_eff),
    .done     (div_done),
    .quotient (div_q)
  );

  // bank cap in fixed point, limited to 32 bits
  assign cap64       = 64'(cfg.max_stored) << FRAC_BITS;
  assign cap32       = (cap64 > 64'h0000_0000_FFFF_FFFF) ? '1 : cap64[31:0];
  assign refill_sum  = {1'b0, banked_permits} + {1'b0, div_q};
  assign refill_bank = (refill_sum < {1'b0, cap32}) ? refill_sum[31:0] : cap32;

  assign ahead     = next_free_time - work.now_us;
  assign want      = CW'(work.permit_count) << FRAC_BITS;
  assign from_bank = (want < CW'(banked_permits)) ? want : CW'(banked_permits);
  assign fresh_w   = want - from_bank;

  assign nft_sum = {1'b0, next_free_time} + 65'(prod_hi) + 65'(prod_lo[LOW-1:FRAC_BITS]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = BK_CHECK;
        end
      end
      BK_CHECK: begin
        if ((work.try_acq && next_free_time > work.limit_us) || work.count_zero) begin
          state_next = BK_EMIT;
        end else begin
          state_next = BK_AGE;
        end
      end
      BK_AGE: begin
        if (work.now_us > next_free_time) begin
          div_start  = 1'b1;
          state_next = BK_DIV;
        end else begin
          state_next = BK_CLAIM;
        end
      end
      BK_DIV: begin
        if (div_done) begin
          state_next = BK_CLAIM;
        end
      end
      BK_CLAIM:  state_next = BK_MUL_HI;
      BK_MUL_HI: state_next = BK_MUL_LO;
      BK_MUL_LO: state_next = BK_UPDATE;
      BK_UPDATE: state_next = BK_EMIT;
      BK_EMIT: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_free_time <= '0;
      banked_permits <= '0;
      res_valid      <= 1'b0;
    end else begin
      if (pop) begin
        res_valid <= 1'b0;
      end
      case (state)
        BK_IDLE: begin
          if (!q_empty) begin
            work <= q_entry;
          end
        end
        BK_CHECK: begin
          pend_wait <= '0;
          if (work.try_acq && next_free_time > work.limit_us) begin
            pend_status <= ST_REFUSED;  // timeout check wins over count check
          end else if (work.count_zero) begin
            pend_status <= ST_INVALID;
          end else begin
            pend_status <= ST_GRANTED;
          end
        end
        BK_AGE: begin
          if (work.now_us <= next_free_time) begin
            pend_wait <= (ahead[63:32] != '0) ? '1 : ahead[31:0];
          end
        end
        BK_DIV: begin
          if (div_done) begin
            banked_permits <= refill_bank;
            next_free_time <= work.now_us;
          end
        end
        BK_CLAIM: begin
          fresh          <= fresh_w[WANTW-1:0];
          banked_permits <= banked_permits - from_bank[31:0];
        end
        BK_MUL_HI: begin
          prod_hi <= 48'(fresh[WANTW-1:FRAC_BITS]) * 48'(cfg.interval_eff);
        end
        BK_MUL_LO: begin
          prod_lo <= LOW'(fresh[FRAC_BITS-1:0]) * LOW'(cfg.interval_eff);
        end
        BK_UPDATE: begin
          next_free_time <= nft_sum[64] ? '1 : nft_sum[63:0];
        end
        BK_EMIT: begin
          if (out_free) begin
            res_valid  <= 1'b1;
            res_status <= pend_status;
            res_wait   <= pend_wait;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/token_bucket_rate_limiter.sv =====
// ----------------------------------------------------------------------------
// token_bucket_rate_limiter
// Smooth-bursty token bucket: grants permits and returns the wait time.
// ----------------------------------------------------------------------------
// Requests enter through a queue-style port (push/full): command, now_us,
// permit_count, timeout_ms. One result per request leaves through
// empty/pop: status (granted, refused by timeout, invalid count) and wait_us.
// The APB port holds interval_us (0x0) and max_stored_permits (0x4); write
// them only while no request is in flight.
// A front stage registers the request and computes the try-acquire limit;
// a two-entry queue feeds the back stage, which owns the bucket state.
// A request that needs a refill also runs the serial divider. Requests are
// executed one at a time; the divider sets the worst-case throughput.
// While a result waits to be popped, the back stage holds its next result
// and the front and queue keep accepting until full rises.
// Reset (synchronous, rst high) clears the bucket, the queue and the result
// register, and sets interval_us to 1000 and max_stored_permits to 0.
// ----------------------------------------------------------------------------
`default_nettype none
`include "token_bucket_rate_limiter_macros.svh"

module token_bucket_rate_limiter #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        command,
  input  wire logic [63:0] now_us,
  input  wire logic [15:0] permit_count,
  input  wire logic [15:0] timeout_ms,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       status,
  output logic [31:0]      wait_us,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import tbrl_pkg::*;

  logic         [31:0] interval_us;
  logic         [15:0] max_stored_permits;
  logic                cfg_wr;
  tbrl_cfg_t           cfg;

  logic                q_push;
  tbrl_req_t           q_wdata;
  logic                q_full;
  logic                q_pop;
  tbrl_req_t           q_rdata;
  logic                q_empty;

  logic                res_valid;
  tbrl_status_t        res_status;
  logic         [31:0] res_wait;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == REG_INTERVAL) ? interval_us : {16'd0, max_stored_permits};

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_us        <= INTERVAL_RST;
      max_stored_permits <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MAX_STORED) begin
        max_stored_permits <= pwdata[15:0];
      end else begin
        interval_us <= pwdata;
      end
    end
  end

  // zero interval behaves as one microsecond
  assign cfg.interval_eff = (interval_us == '0) ? 32'd1 : interval_us;
  assign cfg.max_stored   = max_stored_permits;

  tbrl_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .command      (command),
    .now_us       (now_us),
    .permit_count (permit_count),
    .timeout_ms   (timeout_ms),
    .q_push       (q_push),
    .q_entry      (q_wdata),
    .q_full       (q_full)
  );

  tbrl_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  tbrl_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .q_entry    (q_rdata),
    .q_pop      (q_pop),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_status (res_status),
    .res_wait   (res_wait)
  );

  assign empty   = ~res_valid;
  assign status  = res_status;
  assign wait_us = res_wait;

  `TBRL_ASSERT_NEXT(a_reset_clears, clk, 1'b0, rst, empty && !full, "reset must clear both sides")
  `TBRL_ASSERT_IMPL(a_wait_only_on_grant, clk, rst, !empty && wait_us != 32'd0, status == ST_GRANTED, "nonzero wait on a non-granted result")
  `TBRL_ASSERT_IMPL(a_full_after_push, clk, rst, $rose(full), $past(push), "full rose without an accepted request")

endmodule

`default_nettype wire
